// ----- hw/rtl/memory_gated_admission_scheduler_macros.svh -----
// assertion macros for the admission scheduler
`ifndef MEMORY_GATED_ADMISSION_SCHEDULER_MACROS_SVH
`define MEMORY_GATED_ADMISSION_SCHEDULER_MACROS_SVH

// same-cycle implication, checked out of reset
`define MGAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MGAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mgas_pkg.sv -----
// types and constants shared by the admission scheduler
`default_nettype none

package mgas_pkg;

  localparam int WAIT_DEPTH = 64;
  localparam int RUN_SLOTS  = 16;

  localparam int ID_W       = 16;
  localparam int NEED_W     = 16;
  localparam int WAIT_CNT_W = $clog2(WAIT_DEPTH + 1);
  localparam int RUN_CNT_W  = $clog2(RUN_SLOTS + 1);
  localparam int MEM_SUM_W  = 21;
  localparam int MEM_W      = 20;
  localparam int FIT_W      = MEM_SUM_W + 1;
  localparam int SLOT_W     = 5;
  localparam int CMP_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int RUN_NOW_W  = 5;
  localparam int WAIT_NOW_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic CMD_CREATE = 1'b0;
  localparam logic CMD_KILL   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MEM_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT   = 2'd1;

  localparam logic [MEM_W-1:0]  MEM_CAP_RST    = 20'd1024;
  localparam logic [SLOT_W-1:0] SLOT_LIMIT_RST = 5'd4;

  typedef struct packed {
    logic              command;
    logic [ID_W-1:0]   job_id;
    logic [NEED_W-1:0] mem_need;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic                  admitted;
    logic [ID_W-1:0]       admitted_id;
    logic [RUN_NOW_W-1:0]  running_now;
    logic [WAIT_NOW_W-1:0] waiting_now;
    logic [MEM_W-1:0]      memory_in_use;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [NEED_W-1:0] mem;
  } entry_t;

  typedef struct packed {
    logic occupied;
    logic load;
    logic remove;
    logic pop;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mgas_cell.sv -----
// one list cell: holds a job entry, matches it and shifts toward the head
`default_nettype none

module mgas_cell (
  input  wire logic               clk_i,
  input  wire mgas_pkg::cell_ctl_t ctl_i,
  input  wire logic [mgas_pkg::ID_W-1:0] key_i,
  input  wire mgas_pkg::entry_t   load_i,
  input  wire mgas_pkg::entry_t   next_i,
  input  wire logic               above_i,
  output mgas_pkg::entry_t        entry_o,
  output logic                    above_o,
  output logic                    sel_o
);

  mgas_pkg::entry_t entry_q, entry_d;
  logic hit;

  assign hit     = ctl_i.occupied && (entry_q.id == key_i);
  assign above_o = above_i | hit;
  assign sel_o   = hit & ~above_i;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.pop || (ctl_i.remove && !above_i)) begin
      entry_d = next_i;
    end else if (ctl_i.load) begin
      entry_d = load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/memory_gated_admission_scheduler.sv -----
// top level of the memory-gated admission scheduler
//
// A command is taken when start is high and busy is low. Each command goes through
// an operation phase, in which the waiting and running cell rows do the append or
// the newest-first match and shift-down of a kill, and then an admission phase, in
// which the head of the waiting row is checked against the slot limit and the
// memory capacity and, if it fits, moved to the running row. busy is high in both
// phases, and the result shows on result_o with result_valid_o high for exactly
// the next cycle, at whose end a new command may already be taken.
// The result cannot be held off, so the receiver must take it in that cycle.
// Configuration writes are always ready and belong in idle time only. The rows
// need no clearing after reset.
`default_nettype none

`include "memory_gated_admission_scheduler_macros.svh"

module memory_gated_admission_scheduler (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire mgas_pkg::in_item_t                cmd_i,
  output logic                                   result_valid_o,
  output mgas_pkg::out_item_t                    result_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [mgas_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mgas_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_OP    = 2'd1;
  localparam logic [1:0] PH_ADMIT = 2'd2;

  logic [1:0] state_q, state_d;
  mgas_pkg::in_item_t cmd_q, cmd_d;
  logic [mgas_pkg::STATUS_W-1:0] status_q, status_d;
  logic [mgas_pkg::WAIT_CNT_W-1:0] wait_count_q, wait_count_d;
  logic [mgas_pkg::RUN_CNT_W-1:0] run_count_q, run_count_d;
  logic [mgas_pkg::MEM_SUM_W-1:0] mem_sum_q, mem_sum_d;
  logic [mgas_pkg::MEM_W-1:0] mem_cap_q;
  logic [mgas_pkg::SLOT_W-1:0] slot_limit_q;
  mgas_pkg::out_item_t result_q, result_d;
  logic result_valid_q;

  logic accept, is_op, is_adm;
  logic create_ok, run_rm, wait_rm, admit, fits, slot_free;
  logic [mgas_pkg::NEED_W-1:0] freed;

  mgas_pkg::entry_t wait_entry [mgas_pkg::WAIT_DEPTH];
  mgas_pkg::entry_t wait_next  [mgas_pkg::WAIT_DEPTH];
  mgas_pkg::cell_ctl_t wait_ctl [mgas_pkg::WAIT_DEPTH];
  logic [mgas_pkg::WAIT_DEPTH:0] wait_above;
  logic [mgas_pkg::WAIT_DEPTH-1:0] wait_sel;

  mgas_pkg::entry_t run_entry [mgas_pkg::RUN_SLOTS];
  mgas_pkg::entry_t run_next  [mgas_pkg::RUN_SLOTS];
  mgas_pkg::cell_ctl_t run_ctl [mgas_pkg::RUN_SLOTS];
  logic [mgas_pkg::RUN_SLOTS:0] run_above;
  logic [mgas_pkg::RUN_SLOTS-1:0] run_sel;

  mgas_pkg::entry_t new_entry;
  mgas_pkg::entry_t head;

  assign busy           = (state_q != PH_IDLE);
  assign accept         = start && !busy;
  assign is_op          = (state_q == PH_OP);
  assign is_adm         = (state_q == PH_ADMIT);
  assign cfg_ready_o    = 1'b1;
  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

  assign new_entry.id  = cmd_q.job_id;
  assign new_entry.mem = cmd_q.mem_need;
  assign head          = wait_entry[0];

  // waiting row
  assign wait_above[mgas_pkg::WAIT_DEPTH] = 1'b0;
  for (genvar i = 0; i < mgas_pkg::WAIT_DEPTH; i++) begin : g_wait
    if (i == mgas_pkg::WAIT_DEPTH - 1) begin : g_last
      assign wait_next[i] = '0;
    end else begin : g_mid
      assign wait_next[i] = wait_entry[i+1];
    end
    assign wait_ctl[i].occupied = (mgas_pkg::WAIT_CNT_W'(i) < wait_count_q);
    assign wait_ctl[i].load     = create_ok && (wait_count_q == mgas_pkg::WAIT_CNT_W'(i));
    assign wait_ctl[i].remove   = wait_rm;
    assign wait_ctl[i].pop      = admit;
    mgas_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (wait_ctl[i]),
      .key_i   (cmd_q.job_id),
      .load_i  (new_entry),
      .next_i  (wait_next[i]),
      .above_i (wait_above[i+1]),
      .entry_o (wait_entry[i]),
      .above_o (wait_above[i]),
      .sel_o   (wait_sel[i])
    );
  end

  // running row
  assign run_above[mgas_pkg::RUN_SLOTS] = 1'b0;
  for (genvar i = 0; i < mgas_pkg::RUN_SLOTS; i++) begin : g_run
    if (i == mgas_pkg::RUN_SLOTS - 1) begin : g_last
      assign run_next[i] = '0;
    end else begin : g_mid
      assign run_next[i] = run_entry[i+1];
    end
    assign run_ctl[i].occupied = (mgas_pkg::RUN_CNT_W'(i) < run_count_q);
    assign run_ctl[i].load     = admit && (run_count_q == mgas_pkg::RUN_CNT_W'(i));
    assign run_ctl[i].remove   = run_rm;
    assign run_ctl[i].pop      = 1'b0;
    mgas_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (run_ctl[i]),
      .key_i   (cmd_q.job_id),
      .load_i  (head),
      .next_i  (run_next[i]),
      .above_i (run_above[i+1]),
      .entry_o (run_entry[i]),
      .above_o (run_above[i]),
      .sel_o   (run_sel[i])
    );
  end

  // memory of the removed running job
  always_comb begin
    freed = '0;
    for (int i = 0; i < mgas_pkg::RUN_SLOTS; i++) begin
      freed = freed | (run_sel[i] ? run_entry[i].mem : '0);
    end
  end

  assign create_ok = is_op && (cmd_q.command == mgas_pkg::CMD_CREATE) &&
                     (wait_count_q < mgas_pkg::WAIT_CNT_W'(mgas_pkg::WAIT_DEPTH));
  assign run_rm    = is_op && (cmd_q.command == mgas_pkg::CMD_KILL) && run_above[0];
  assign wait_rm   = is_op && (cmd_q.command == mgas_pkg::CMD_KILL) && !run_above[0] &&
                     wait_above[0];

  assign slot_free = (mgas_pkg::CMP_W'(run_count_q) < mgas_pkg::CMP_W'(slot_limit_q)) &&
                     (run_count_q < mgas_pkg::RUN_CNT_W'(mgas_pkg::RUN_SLOTS));
  assign fits      = (mgas_pkg::FIT_W'(mem_sum_q) + mgas_pkg::FIT_W'(head.mem)) <=
                     mgas_pkg::FIT_W'(mem_cap_q);
  assign admit     = is_adm && (wait_count_q != '0) && slot_free && fits;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    status_d     = status_q;
    wait_count_d = wait_count_q;
    run_count_d  = run_count_q;
    mem_sum_d    = mem_sum_q;
    result_d     = result_q;
    if (accept) begin
      cmd_d = cmd_i;
    end
    case (state_q)
      PH_IDLE: begin
        if (start) begin
          state_d = PH_OP;
        end
      end
      PH_OP: begin
        state_d  = PH_ADMIT;
        status_d = mgas_pkg::ST_DONE;
        if (cmd_q.command == mgas_pkg::CMD_CREATE) begin
          if (create_ok) begin
            wait_count_d = wait_count_q + 1'b1;
          end else begin
            status_d = mgas_pkg::ST_FULL;
          end
        end else if (run_rm) begin
          run_count_d = run_count_q - 1'b1;
          mem_sum_d   = (mem_sum_q >= mgas_pkg::MEM_SUM_W'(freed)) ?
                        (mem_sum_q - mgas_pkg::MEM_SUM_W'(freed)) : '0;
        end else if (wait_rm) begin
          wait_count_d = wait_count_q - 1'b1;
        end else begin
          status_d = mgas_pkg::ST_NOT_FOUND;
        end
      end
      PH_ADMIT: begin
        state_d = PH_IDLE;
        if (admit) begin
          run_count_d  = run_count_q + 1'b1;
          wait_count_d = wait_count_q - 1'b1;
          mem_sum_d    = mem_sum_q + mgas_pkg::MEM_SUM_W'(head.mem);
        end
        result_d.status        = status_q;
        result_d.admitted      = admit;
        result_d.admitted_id   = admit ? head.id : '0;
        result_d.running_now   = mgas_pkg::RUN_NOW_W'(run_count_d);
        result_d.waiting_now   = mgas_pkg::WAIT_NOW_W'(wait_count_d);
        result_d.memory_in_use = (|mem_sum_d[mgas_pkg::MEM_SUM_W-1:mgas_pkg::MEM_W]) ?
                                 '1 : mem_sum_d[mgas_pkg::MEM_W-1:0];
      end
      default: begin
        state_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= PH_IDLE;
      wait_count_q   <= '0;
      run_count_q    <= '0;
      mem_sum_q      <= '0;
      result_valid_q <= 1'b0;
      mem_cap_q      <= mgas_pkg::MEM_CAP_RST;
      slot_limit_q   <= mgas_pkg::SLOT_LIMIT_RST;
    end else begin
      state_q        <= state_d;
      wait_count_q   <= wait_count_d;
      run_count_q    <= run_count_d;
      mem_sum_q      <= mem_sum_d;
      result_valid_q <= is_adm;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == mgas_pkg::CFG_MEM_CAPACITY) begin
          mem_cap_q <= cfg_data_i[mgas_pkg::MEM_W-1:0];
        end else if (cfg_index_i == mgas_pkg::CFG_SLOT_LIMIT) begin
          slot_limit_q <= cfg_data_i[mgas_pkg::SLOT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    status_q <= status_d;
    result_q <= result_d;
  end

  `MGAS_ASSERT_NEXT(a_start_to_op, accept, state_q == PH_OP, "accepted item did not start")
  `MGAS_ASSERT_NEXT(a_strobe_after_admit, is_adm, result_valid_q, "result strobe missing")
  `MGAS_ASSERT_NOW(a_run_bound, 1'b1, run_count_q <= mgas_pkg::RUN_CNT_W'(mgas_pkg::RUN_SLOTS), "run count overflow")
  `MGAS_ASSERT_NOW(a_wait_bound, 1'b1, wait_count_q <= mgas_pkg::WAIT_CNT_W'(mgas_pkg::WAIT_DEPTH), "wait count overflow")
  `MGAS_ASSERT_NEXT(a_admit_fits, admit, mgas_pkg::FIT_W'(mem_sum_q) <= mgas_pkg::FIT_W'(mem_cap_q), "admission exceeded capacity")

endmodule

`default_nettype wire
